/* src/csri_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package csri_pkg;

	localparam int CornerCount = 7;
	localparam int CodeWidth   = 5;
	localparam int PieceWidth  = 4;
	localparam int LaneCount   = 11;
	localparam int LaneWidth   = 4;
	localparam int LaneBits    = LaneCount * LaneWidth;
	localparam int RankWidth   = 17;
	localparam int OrientWidth = 12;
	localparam int PermWtWidth = 13;
	localparam int OriWtWidth  = 10;
	localparam int SumWidth    = RankWidth + OrientWidth;
	localparam int IndexWidth  = 27;
	localparam int AddrWidth   = 26;
	localparam int InBits      = CornerCount * CodeWidth;
	localparam int InBytes     = (InBits + 7) / 8;
	localparam int OutBits     = IndexWidth + AddrWidth + 1;
	localparam int OutBytes    = (OutBits + 7) / 8;

	// only lanes 0..10 can ever be read; borrows only move upward
	localparam logic [LaneBits-1:0] LanesStart  = 44'hA98_7654_3210;
	localparam logic [LaneBits-1:0] LanesStep   = 44'h111_1111_1110;
	localparam logic [SumWidth-1:0] OrientScale = SumWidth'(2187);

	typedef logic [CodeWidth-1:0]   code_t;
	typedef logic [PieceWidth-1:0]  piece_t;
	typedef logic [LaneWidth-1:0]   lane_t;
	typedef logic [LaneCount-1:0][LaneWidth-1:0] lanes_t;
	typedef logic [1:0]             orient_t;
	typedef code_t [CornerCount-1:0] codes_t;

	typedef struct packed {
		codes_t                 codes;
		lanes_t                 lanes;
		logic [RankWidth-1:0]   rank;
		logic [OrientWidth-1:0] orient;
	} stage_t;

	typedef struct packed {
		logic                  low_nibble;
		logic [AddrWidth-1:0]  byte_address;
		logic [IndexWidth-1:0] state_index;
	} result_t;

	function automatic piece_t code_piece(input code_t c);
		piece_t p;
		if (c >= code_t'(30))      p = piece_t'(10);
		else if (c >= code_t'(27)) p = piece_t'(9);
		else if (c >= code_t'(24)) p = piece_t'(8);
		else if (c >= code_t'(21)) p = piece_t'(7);
		else if (c >= code_t'(18)) p = piece_t'(6);
		else if (c >= code_t'(15)) p = piece_t'(5);
		else if (c >= code_t'(12)) p = piece_t'(4);
		else if (c >= code_t'(9))  p = piece_t'(3);
		else if (c >= code_t'(6))  p = piece_t'(2);
		else if (c >= code_t'(3))  p = piece_t'(1);
		else                       p = piece_t'(0);
		return p;
	endfunction

	function automatic orient_t code_orient(input code_t c);
		piece_t p;
		code_t  base;
		p    = code_piece(c);
		base = code_t'({p, 1'b0}) + code_t'(p);
		return orient_t'(c - base);
	endfunction

	function automatic logic [PermWtWidth-1:0] perm_weight(input int k);
		logic [PermWtWidth-1:0] w;
		unique case (k)
			0: w = PermWtWidth'(5040);
			1: w = PermWtWidth'(720);
			2: w = PermWtWidth'(120);
			3: w = PermWtWidth'(24);
			4: w = PermWtWidth'(6);
			5: w = PermWtWidth'(2);
			default: w = PermWtWidth'(1);
		endcase
		return w;
	endfunction

	function automatic logic [OriWtWidth-1:0] orient_weight(input int k);
		logic [OriWtWidth-1:0] w;
		unique case (k)
			0: w = OriWtWidth'(1);
			1: w = OriWtWidth'(3);
			2: w = OriWtWidth'(9);
			3: w = OriWtWidth'(27);
			4: w = OriWtWidth'(81);
			5: w = OriWtWidth'(243);
			default: w = OriWtWidth'(729);
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

/* src/corner_state_rank_index_unit.sv */
// corner state rank index unit
// maps seven corner codes (piece*3 + orientation) to a state index:
// lehmer rank of the pieces times 2187 plus the base-3 orientation number,
// together with the byte address (index/2) and nibble select (index odd)
// input channel s_axis: one request per seven-corner state, code i in
//   tdata bits 5i+4..5i
// output channel m_axis: one result per request, in request order
// pipeline: 8 register stages; one lane-update stage per corner (a 44-bit
//   subtract and a small constant multiply each) plus a final scale stage
//   with the 17x12 multiply-add
// throughput: one request per cycle while m_axis_tready is high; each stage holds
//   its own valid bit and takes new data whenever it is empty or its successor
//   moves, so bubbles are squeezed out
// stall: when m_axis_tready is low, the result stays on m_axis and requests
//   keep entering until the pipeline is full; then s_axis_tready drops
// reset: arst_n clears all valid bits; no item is in flight afterward
`timescale 1ns / 1ps
`default_nettype none

module corner_state_rank_index_unit
	import csri_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	// corner_code_0 .. corner_code_6, 5 bits each, then zero fill
	input  wire logic [InBytes*8-1:0]  s_axis_tdata,
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	// state_index[26:0], byte_address[52:27], low_nibble[53], then zero fill
	output logic [OutBytes*8-1:0]      m_axis_tdata
);

	codes_t  codes;
	logic    mid_valid;
	logic    mid_ready;
	stage_t  mid_stage;
	result_t result;

	always_comb begin
		for (int i = 0; i < CornerCount; i++) begin
			codes[i] = s_axis_tdata[i*CodeWidth +: CodeWidth];
		end
	end

	csri_lehmer_pipe u_lehmer (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_codes  (codes),
		.out_valid (mid_valid),
		.out_ready (mid_ready),
		.out_stage (mid_stage)
	);

	csri_scale u_scale (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (mid_valid),
		.in_ready   (mid_ready),
		.in_stage   (mid_stage),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_result (result)
	);

	assign m_axis_tdata = (OutBytes*8)'(result);

endmodule

`default_nettype wire

/* src/csri_lehmer_pipe.sv */
`timescale 1ns / 1ps
`default_nettype none

module csri_lehmer_pipe
	import csri_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   in_valid,
	output logic        in_ready,
	input  wire codes_t in_codes,
	output logic        out_valid,
	input  wire logic   out_ready,
	output stage_t      out_stage
);

	stage_t data_s  [CornerCount];
	logic   valid_s [CornerCount];
	logic   ready   [CornerCount+1];

	assign ready[CornerCount] = out_ready;
	assign in_ready  = ready[0];
	assign out_valid = valid_s[CornerCount-1];
	assign out_stage = data_s[CornerCount-1];

	genvar k;
	generate
		for (k = 0; k < CornerCount; k++) begin : g_step
			stage_t prev;
			logic   prev_valid;
			stage_t nxt;
			piece_t piece;
			lane_t  digit;

			if (k == 0) begin : g_first
				always_comb begin
					prev.codes  = in_codes;
					prev.lanes  = lanes_t'(LanesStart);
					prev.rank   = '0;
					prev.orient = '0;
					prev_valid  = in_valid;
				end
			end else begin : g_next
				always_comb begin
					prev       = data_s[k-1];
					prev_valid = valid_s[k-1];
				end
			end

			assign ready[k] = !valid_s[k] || ready[k+1];

			// digit is lane p, then every lane above p drops by one
			always_comb begin
				piece      = code_piece(prev.codes[k]);
				digit      = prev.lanes[piece];
				nxt        = prev;
				nxt.lanes  = lanes_t'(LaneBits'(prev.lanes)
					- LaneBits'(LanesStep << {piece, 2'b00}));
				nxt.rank   = prev.rank
					+ RankWidth'(digit) * RankWidth'(perm_weight(k));
				nxt.orient = prev.orient
					+ OrientWidth'(code_orient(prev.codes[k]))
					* OrientWidth'(orient_weight(k));
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					valid_s[k] <= 1'b0;
				end else if (ready[k]) begin
					valid_s[k] <= prev_valid;
				end
			end

			always_ff @(posedge clk) begin
				if (ready[k] && prev_valid) begin
					data_s[k] <= nxt;
				end
			end
		end
	endgenerate

endmodule

`default_nettype wire

/* src/csri_scale.sv */
`timescale 1ns / 1ps
`default_nettype none

module csri_scale
	import csri_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   in_valid,
	output logic        in_ready,
	input  wire stage_t in_stage,
	output logic        out_valid,
	input  wire logic   out_ready,
	output result_t     out_result
);

	logic                valid_s8;
	result_t             result_s8;
	logic [SumWidth-1:0] total;

	assign in_ready = !valid_s8 || out_ready;

	always_comb begin
		total = SumWidth'(in_stage.rank) * OrientScale + SumWidth'(in_stage.orient);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s8 <= 1'b0;
		end else if (in_ready) begin
			valid_s8 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			result_s8.state_index  <= total[IndexWidth-1:0];
			result_s8.byte_address <= total[IndexWidth-1:1];
			result_s8.low_nibble   <= total[0];
		end
	end

	assign out_valid  = valid_s8;
	assign out_result = result_s8;

endmodule

`default_nettype wire
